// File: design/reflective_sensor_scan_sequencer_unit_macros.svh
// assertion macros used by the scan sequencer core
`ifndef REFLECTIVE_SENSOR_SCAN_SEQUENCER_UNIT_MACROS_SVH
`define REFLECTIVE_SENSOR_SCAN_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define RSSS_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rsss_pkg.sv
// shared types and constants of the reflective sensor scan sequencer
package rsss_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 12;

   localparam int CMD_WIDTH    = 2;
   localparam int ADC_WIDTH    = 12;
   localparam int WAIT_WIDTH   = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int OUT_MASK_W   = 8;
   localparam int OUT_SEL_W    = 3;
   localparam int WIDE_MASK_W  = 16;

   localparam logic [ADC_WIDTH-1:0] SAMPLE_MASK = ADC_WIDTH'((64'd1 << SAMPLE_BITS) - 64'd1);

   localparam logic [CMD_WIDTH-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_WAIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_WAIT = 2'd2;

   localparam logic [ADC_WIDTH-1:0]  THRESHOLD_RESET   = 12'd2048;
   localparam logic [WAIT_WIDTH-1:0] READ_WAIT_RESET   = 16'd10;
   localparam logic [WAIT_WIDTH-1:0] SETTLE_WAIT_RESET = 16'd10;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] command;
      logic [ADC_WIDTH-1:0] adc_value;
   } item_type;

   typedef struct packed {
      logic [ADC_WIDTH-1:0]  detect_threshold;
      logic [WAIT_WIDTH-1:0] read_wait_ticks;
      logic [WAIT_WIDTH-1:0] settle_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic [OUT_MASK_W-1:0] emitter_mask;
      logic                  mux_enable;
      logic [OUT_SEL_W-1:0]  mux_select;
      logic                  adc_request;
      logic                  busy_res;
      logic [OUT_MASK_W-1:0] detect_mask;
      logic                  result_valid;
      logic                  start_rejected;
   } result_type;

endpackage

// File: design/reflective_sensor_scan_sequencer_unit.sv
// top level of the reflective sensor scan sequencer
//
// requests arrive on req_ (valid/stall) carrying a command and an adc sample:
// start scan, timer tick or adc sample complete. each request yields exactly
// one response on rsp_ (valid/stall) showing emitter, mux and adc request
// drives, busy, the last published detect mask and the done/reject flags.
// a request is registered, then evaluated combinationally against the scan
// state and written to the response register. throughput is one request per
// cycle while rsp_stall is low, set by the single state update per request.
// when rsp_stall is high the response register holds; one more request is
// taken into the input register, then req_stall rises until the response
// moves on.
// csr_ (valid/ready) writes threshold and wait registers by index; write only
// while idle. reset clears the scan state, the published mask, the valid bits
// of both register stages and restores the configuration defaults.
module reflective_sensor_scan_sequencer_unit #(
   parameter int NUM_CHANNELS = rsss_pkg::NUM_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rsss_pkg::CMD_WIDTH-1:0]      req_command,
   input  logic [rsss_pkg::ADC_WIDTH-1:0]      req_adc_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rsss_pkg::OUT_MASK_W-1:0]     rsp_emitter_mask,
   output logic                                rsp_mux_enable,
   output logic [rsss_pkg::OUT_SEL_W-1:0]      rsp_mux_select,
   output logic                                rsp_adc_request,
   output logic                                rsp_busy_res,
   output logic [rsss_pkg::OUT_MASK_W-1:0]     rsp_detect_mask,
   output logic                                rsp_result_valid,
   output logic                                rsp_start_rejected,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsss_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rsss_pkg::item_type   req_item;
   rsss_pkg::item_type   item;
   logic                 item_valid;
   logic                 item_take;
   rsss_pkg::cfg_type    cfg;
   rsss_pkg::result_type rsp;

   assign req_item.command   = req_command;
   assign req_item.adc_value = req_adc_value;

   rsss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsss_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   rsss_core #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_emitter_mask   = rsp.emitter_mask;
   assign rsp_mux_enable     = rsp.mux_enable;
   assign rsp_mux_select     = rsp.mux_select;
   assign rsp_adc_request    = rsp.adc_request;
   assign rsp_busy_res       = rsp.busy_res;
   assign rsp_detect_mask    = rsp.detect_mask;
   assign rsp_result_valid   = rsp.result_valid;
   assign rsp_start_rejected = rsp.start_rejected;

endmodule

// File: design/rsss_csr.sv
// configuration registers of the scan sequencer
module rsss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rsss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rsss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rsss_pkg::cfg_type                cfg
);

   rsss_pkg::cfg_type cfg_ff;
   rsss_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rsss_pkg::CSR_THRESHOLD:
               cfg_in.detect_threshold = csr_wdata[rsss_pkg::ADC_WIDTH-1:0];
            rsss_pkg::CSR_READ_WAIT:
               cfg_in.read_wait_ticks = csr_wdata[rsss_pkg::WAIT_WIDTH-1:0];
            rsss_pkg::CSR_SETTLE_WAIT:
               cfg_in.settle_wait_ticks = csr_wdata[rsss_pkg::WAIT_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold  <= rsss_pkg::THRESHOLD_RESET;
         cfg_ff.read_wait_ticks   <= rsss_pkg::READ_WAIT_RESET;
         cfg_ff.settle_wait_ticks <= rsss_pkg::SETTLE_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/rsss_in_stage.sv
// input register of the scan sequencer
module rsss_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rsss_pkg::item_type req_item,
   output logic               item_valid,
   output rsss_pkg::item_type item,
   input  logic               item_take
);

   logic               valid_ff;
   logic               valid_in;
   rsss_pkg::item_type item_ff;
   logic               load;

   assign req_stall = valid_ff && !item_take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: design/rsss_core.sv
// scan state machine and result register of the scan sequencer
`include "reflective_sensor_scan_sequencer_unit_macros.svh"

module rsss_core #(
   parameter int NUM_CHANNELS = rsss_pkg::NUM_CHANNELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  rsss_pkg::item_type   item,
   output logic                 item_take,
   input  rsss_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsss_pkg::result_type rsp
);

   localparam int ChanBits = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [ChanBits-1:0] LastChan = ChanBits'(NUM_CHANNELS - 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READ,
      PH_SAMPLE,
      PH_SETTLE
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [ChanBits-1:0]               chan_ff, chan_in;
   logic [rsss_pkg::WAIT_WIDTH-1:0]   tick_ff, tick_in;
   logic [NUM_CHANNELS-1:0]           partial_ff, partial_in;
   logic [NUM_CHANNELS-1:0]           published_ff, published_in;
   logic                              rsp_valid_ff;
   rsss_pkg::result_type              result_ff, result_in;

   logic [rsss_pkg::WAIT_WIDTH:0]     tick_sum;
   logic [rsss_pkg::ADC_WIDTH-1:0]    sample;
   logic                              adc_req_in;
   logic                              done_in;
   logic                              rejected_in;
   logic                              busy_in;
   logic [rsss_pkg::WIDE_MASK_W-1:0]  emit_wide;
   logic [rsss_pkg::WIDE_MASK_W-1:0]  chan_wide;
   logic [rsss_pkg::WIDE_MASK_W-1:0]  published_wide;

   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign tick_sum  = {1'b0, tick_ff} + (rsss_pkg::WAIT_WIDTH + 1)'(1);
   assign sample    = item.adc_value & rsss_pkg::SAMPLE_MASK;

   always_comb begin
      phase_in     = phase_ff;
      chan_in      = chan_ff;
      tick_in      = tick_ff;
      partial_in   = partial_ff;
      published_in = published_ff;
      adc_req_in   = 1'b0;
      done_in      = 1'b0;
      rejected_in  = 1'b0;
      case (item.command)
         rsss_pkg::CMD_START: begin
            if (phase_ff == PH_IDLE) begin
               phase_in   = PH_READ;
               chan_in    = '0;
               tick_in    = '0;
               partial_in = '0;
            end else begin
               rejected_in = 1'b1;
            end
         end
         rsss_pkg::CMD_TICK: begin
            if (phase_ff == PH_READ) begin
               if (tick_sum >= {1'b0, cfg.read_wait_ticks}) begin
                  phase_in   = PH_SAMPLE;
                  tick_in    = '0;
                  adc_req_in = 1'b1;
               end else begin
                  tick_in = tick_sum[rsss_pkg::WAIT_WIDTH-1:0];
               end
            end else if (phase_ff == PH_SETTLE) begin
               if (tick_sum >= {1'b0, cfg.settle_wait_ticks}) begin
                  phase_in = PH_READ;
                  tick_in  = '0;
                  chan_in  = chan_ff + ChanBits'(1);
               end else begin
                  tick_in = tick_sum[rsss_pkg::WAIT_WIDTH-1:0];
               end
            end
         end
         rsss_pkg::CMD_SAMPLE: begin
            if (phase_ff == PH_SAMPLE) begin
               if (sample < cfg.detect_threshold) begin
                  partial_in = partial_ff | (NUM_CHANNELS'(1) << chan_ff);
               end
               tick_in = '0;
               if (chan_ff == LastChan) begin
                  published_in = partial_in;
                  phase_in     = PH_IDLE;
                  chan_in      = '0;
                  done_in      = 1'b1;
               end else begin
                  phase_in = PH_SETTLE;
               end
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   assign busy_in        = (phase_in != PH_IDLE);
   assign chan_wide      = rsss_pkg::WIDE_MASK_W'(chan_in);
   assign emit_wide      = (phase_in == PH_READ || phase_in == PH_SAMPLE)
                           ? (rsss_pkg::WIDE_MASK_W'(1) << chan_in) : '0;
   assign published_wide = rsss_pkg::WIDE_MASK_W'(published_in);

   always_comb begin
      result_in.emitter_mask   = emit_wide[rsss_pkg::OUT_MASK_W-1:0];
      result_in.mux_enable     = busy_in;
      result_in.mux_select     = busy_in ? chan_wide[rsss_pkg::OUT_SEL_W-1:0] : '0;
      result_in.adc_request    = adc_req_in;
      result_in.busy_res       = busy_in;
      result_in.detect_mask    = published_wide[rsss_pkg::OUT_MASK_W-1:0];
      result_in.result_valid   = done_in;
      result_in.start_rejected = rejected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         chan_ff      <= '0;
         tick_ff      <= '0;
         partial_ff   <= '0;
         published_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            phase_ff     <= phase_in;
            chan_ff      <= chan_in;
            tick_ff      <= tick_in;
            partial_ff   <= partial_in;
            published_ff <= published_in;
            rsp_valid_ff <= 1'b1;
            result_ff    <= result_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = result_ff;

   `RSSS_ASSERT_HOLDS(a_idle_chan_zero, phase_ff == PH_IDLE, chan_ff == '0, "channel set while idle")
   `RSSS_ASSERT_NEXT(a_req_enters_sample, item_take && adc_req_in, phase_ff == PH_SAMPLE, "sample request without sample wait")
   `RSSS_ASSERT_NEXT(a_reject_keeps_scan, item_take && rejected_in, $stable(phase_ff) && $stable(chan_ff), "rejected start changed scan")
   `RSSS_ASSERT_HOLDS(a_done_is_idle, rsp_valid_ff && result_ff.result_valid, !result_ff.busy_res && result_ff.emitter_mask == '0, "scan done while busy")

endmodule
